### rtl/lcqfp_pkg.sv
`timescale 1ns / 1ps

package lcqfp_pkg;

    // Pool geometry; slot value POOL_DEPTH stands for "no slot" in every link.
    localparam int POOL_DEPTH = 16;
    localparam int SLOT_W     = $clog2(POOL_DEPTH);
    localparam int LINK_W     = SLOT_W + 1;
    localparam int CNT_W      = LINK_W;

    localparam logic [LINK_W-1:0] NONE_SLOT = LINK_W'(POOL_DEPTH);

    // Beat field widths
    localparam int FUNC_W   = 2;
    localparam int CODE_W   = 8;
    localparam int TAG_W    = 8;
    localparam int BEFORE_W = 5;
    localparam int STAT_W   = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EXHAUST  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTQUEUE = 2'd3;

    // Link memory write and read requests
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [LINK_W-1:0] data;
    } t_link_wr;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [LINK_W-1:0] dflt;
    } t_link_rd;

endpackage

### rtl/lcqfp_if.sv
`timescale 1ns / 1ps

interface lcqfp_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [lcqfp_pkg::FUNC_W-1:0]    func;
    logic [lcqfp_pkg::CODE_W-1:0]    cmd_code;
    logic [lcqfp_pkg::TAG_W-1:0]     cmd_state;
    logic [lcqfp_pkg::BEFORE_W-1:0]  before_slot;

    modport source (output valid, output func, output cmd_code, output cmd_state,
                    output before_slot, input ready);
    modport sink   (input valid, input func, input cmd_code, input cmd_state,
                    input before_slot, output ready);
endinterface

interface lcqfp_res_if;
    logic                            valid;
    logic                            ready;
    logic [lcqfp_pkg::STAT_W-1:0]    status;
    logic [lcqfp_pkg::SLOT_W-1:0]    slot;
    logic [lcqfp_pkg::CODE_W-1:0]    out_code;
    logic [lcqfp_pkg::TAG_W-1:0]     out_state;
    logic [lcqfp_pkg::CNT_W-1:0]     free_count;
    logic                            queue_empty;

    modport source (output valid, output status, output slot, output out_code,
                    output out_state, output free_count, output queue_empty,
                    input ready);
    modport sink   (input valid, input status, input slot, input out_code,
                    input out_state, input free_count, input queue_empty,
                    output ready);
endinterface

### rtl/linked_command_queue_with_free_pool_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Modport  Beat contents
// --------  ---  -------  -------------------------------------------------------
// i_cmd     in   sink     func, cmd_code, cmd_state, before_slot
// o_res     out  source   status, slot, out_code, out_state, free_count, queue_empty
//
// Steps per beat, accept to result in the output register: append and insert go
// TAKE, LINK, FIN; pop REL, FIN; clear REL until the list runs out, FIN; errors
// FIN. A small sequencer walks the link memories (one read, one write port each).
// Reset (synchronous, active low) takes effect at once: the link memories track
// written entries, so no clearing pass is needed.
// A stalled result sits in the output register; the next command is accepted
// meanwhile and holds in its final step until the register frees up.
module linked_command_queue_with_free_pool_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lcqfp_cmd_if.sink    i_cmd,
    lcqfp_res_if.source  o_res
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;  // waiting for a command beat
    localparam logic [ST_W-1:0] ST_TAKE = 3'd1;  // pull slot off the free list
    localparam logic [ST_W-1:0] ST_LINK = 3'd2;  // hook new slot into neighbours
    localparam logic [ST_W-1:0] ST_REL  = 3'd3;  // release head (pop or clear walk)
    localparam logic [ST_W-1:0] ST_FIN  = 3'd4;  // hand result to output register

    localparam int SW = lcqfp_pkg::SLOT_W;
    localparam int LW = lcqfp_pkg::LINK_W;

    logic [ST_W-1:0]                r_state;
    logic [LW-1:0]                  r_head;
    logic [LW-1:0]                  r_tail;
    logic [LW-1:0]                  r_fhead;
    logic [lcqfp_pkg::CNT_W-1:0]    r_fleft;
    logic [lcqfp_pkg::POOL_DEPTH-1:0] r_queued;

    // per-command working registers
    logic                           r_op_ins;
    logic                           r_op_clr;
    logic [SW-1:0]                  r_s;
    logic [SW-1:0]                  r_b;
    logic [LW-1:0]                  r_p;
    logic [lcqfp_pkg::CODE_W-1:0]   r_in_code;
    logic [lcqfp_pkg::TAG_W-1:0]    r_in_tag;
    logic [lcqfp_pkg::STAT_W-1:0]   r_status;
    logic [SW-1:0]                  r_slot;
    logic [lcqfp_pkg::CODE_W-1:0]   r_code;
    logic [lcqfp_pkg::TAG_W-1:0]    r_tag;

    // entry payload stores, written on allocation, read on pop
    logic [lcqfp_pkg::CODE_W-1:0]   r_code_mem [lcqfp_pkg::POOL_DEPTH];
    logic [lcqfp_pkg::TAG_W-1:0]    r_tag_mem  [lcqfp_pkg::POOL_DEPTH];
    logic [lcqfp_pkg::CODE_W-1:0]   r_rd_code;
    logic [lcqfp_pkg::TAG_W-1:0]    r_rd_tag;

    // output register
    logic                           r_ov;
    logic [lcqfp_pkg::STAT_W-1:0]   r_o_status;
    logic [SW-1:0]                  r_o_slot;
    logic [lcqfp_pkg::CODE_W-1:0]   r_o_code;
    logic [lcqfp_pkg::TAG_W-1:0]    r_o_tag;
    logic [lcqfp_pkg::CNT_W-1:0]    r_o_free;
    logic                           r_o_empty;

    lcqfp_pkg::t_link_wr  nx_wr, pv_wr;
    lcqfp_pkg::t_link_rd  nx_rd, pv_rd;
    logic [LW-1:0]        nx_data, pv_data;

    logic          accept;
    logic          fin_load;
    logic          alloc_op;
    logic          head_ok;
    logic          pool_ok;
    logic [SW-1:0] rd_addr;
    logic [LW-1:0] link_tgt;

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign fin_load = (r_state == ST_FIN) && (!r_ov || o_res.ready);
    assign alloc_op = (i_cmd.func == lcqfp_pkg::FUNC_APPEND) ||
                      (i_cmd.func == lcqfp_pkg::FUNC_INSERT);
    assign head_ok  = r_head < lcqfp_pkg::NONE_SLOT;
    assign pool_ok  = (r_fhead < lcqfp_pkg::NONE_SLOT) && (r_fleft != '0);
    // neighbour whose next link must point at the new slot
    assign link_tgt = r_op_ins ? r_p : r_tail;

    // at accept: free head for allocation, list head for pop/clear;
    // in the clear walk: the head that is about to become current
    always_comb begin
        if (r_state == ST_REL) begin
            rd_addr = nx_data[SW-1:0];
        end else if (alloc_op) begin
            rd_addr = r_fhead[SW-1:0];
        end else begin
            rd_addr = r_head[SW-1:0];
        end
    end

    always_comb begin
        nx_rd.en   = accept || (r_state == ST_REL);
        nx_rd.addr = rd_addr;
        nx_rd.dflt = LW'(rd_addr) + LW'(1);       // reset chain: slot i -> i+1

        pv_rd.en   = accept;
        pv_rd.addr = i_cmd.before_slot[SW-1:0];
        pv_rd.dflt = lcqfp_pkg::NONE_SLOT;

        nx_wr = '0;
        pv_wr = '0;
        case (r_state)
            ST_TAKE: begin
                nx_wr.en   = 1'b1;
                nx_wr.addr = r_s;
                nx_wr.data = r_op_ins ? LW'(r_b) : lcqfp_pkg::NONE_SLOT;
                pv_wr.en   = 1'b1;
                pv_wr.addr = r_s;
                pv_wr.data = r_op_ins ? pv_data : r_tail;
            end
            ST_LINK: begin
                nx_wr.en   = link_tgt < lcqfp_pkg::NONE_SLOT;
                nx_wr.addr = link_tgt[SW-1:0];
                nx_wr.data = LW'(r_s);
                pv_wr.en   = r_op_ins;
                pv_wr.addr = r_b;
                pv_wr.data = LW'(r_s);
            end
            ST_REL: begin
                // released slot goes on the front of the free list
                nx_wr.en   = 1'b1;
                nx_wr.addr = r_head[SW-1:0];
                nx_wr.data = r_fhead;
                // new head loses its back link
                pv_wr.en   = nx_data < lcqfp_pkg::NONE_SLOT;
                pv_wr.addr = nx_data[SW-1:0];
                pv_wr.data = lcqfp_pkg::NONE_SLOT;
            end
            default: begin
                nx_wr = '0;
                pv_wr = '0;
            end
        endcase
    end

    lcqfp_link_ram u_next (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (nx_wr),
        .i_rd      (nx_rd),
        .o_rd_data (nx_data)
    );

    lcqfp_link_ram u_prev (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (pv_wr),
        .i_rd      (pv_rd),
        .o_rd_data (pv_data)
    );

    // payload stores
    always_ff @(posedge i_clk) begin
        if (r_state == ST_TAKE) begin
            r_code_mem[r_s] <= r_in_code;
            r_tag_mem[r_s]  <= r_in_tag;
        end
        if (accept) begin
            r_rd_code <= r_code_mem[r_head[SW-1:0]];
            r_rd_tag  <= r_tag_mem[r_head[SW-1:0]];
        end
    end

    // sequencer and list pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= lcqfp_pkg::NONE_SLOT;
            r_tail   <= lcqfp_pkg::NONE_SLOT;
            r_fhead  <= '0;
            r_fleft  <= lcqfp_pkg::CNT_W'(lcqfp_pkg::POOL_DEPTH);
            r_queued <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_cmd.func)
                            lcqfp_pkg::FUNC_APPEND,
                            lcqfp_pkg::FUNC_INSERT: begin
                                if (!pool_ok) begin
                                    r_state <= ST_FIN;
                                end else if (i_cmd.func == lcqfp_pkg::FUNC_APPEND ||
                                             i_cmd.before_slot == lcqfp_pkg::NONE_SLOT) begin
                                    r_state <= ST_TAKE;
                                end else if (i_cmd.before_slot > lcqfp_pkg::NONE_SLOT ||
                                             !r_queued[i_cmd.before_slot[SW-1:0]]) begin
                                    r_state <= ST_FIN;
                                end else begin
                                    r_state <= ST_TAKE;
                                end
                            end
                            default: begin
                                r_state <= head_ok ? ST_REL : ST_FIN;
                            end
                        endcase
                    end
                end
                ST_TAKE: begin
                    r_fhead       <= nx_data;
                    r_queued[r_s] <= 1'b1;
                    r_fleft       <= r_fleft - lcqfp_pkg::CNT_W'(1);
                    r_state       <= ST_LINK;
                end
                ST_LINK: begin
                    if (!r_op_ins) begin
                        if (!(r_tail < lcqfp_pkg::NONE_SLOT)) begin
                            r_head <= LW'(r_s);
                        end
                        r_tail <= LW'(r_s);
                    end else if (!(r_p < lcqfp_pkg::NONE_SLOT)) begin
                        r_head <= LW'(r_s);
                    end
                    r_state <= ST_FIN;
                end
                ST_REL: begin
                    r_head <= nx_data;
                    if (!(nx_data < lcqfp_pkg::NONE_SLOT)) begin
                        r_tail <= lcqfp_pkg::NONE_SLOT;
                    end
                    r_queued[r_head[SW-1:0]] <= 1'b0;
                    r_fhead <= r_head;
                    r_fleft <= r_fleft + lcqfp_pkg::CNT_W'(1);
                    // clear keeps walking until the list runs out
                    if (!r_op_clr || !(nx_data < lcqfp_pkg::NONE_SLOT)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fin_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // working payload, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_s       <= r_fhead[SW-1:0];
                    r_b       <= i_cmd.before_slot[SW-1:0];
                    r_in_code <= i_cmd.cmd_code;
                    r_in_tag  <= i_cmd.cmd_state;
                    r_op_clr  <= i_cmd.func == lcqfp_pkg::FUNC_CLEAR;
                    r_op_ins  <= (i_cmd.func == lcqfp_pkg::FUNC_INSERT) &&
                                 (i_cmd.before_slot != lcqfp_pkg::NONE_SLOT);
                    r_slot    <= '0;
                    r_code    <= '0;
                    r_tag     <= '0;
                    r_status  <= lcqfp_pkg::STAT_OK;
                    case (i_cmd.func)
                        lcqfp_pkg::FUNC_APPEND: begin
                            if (!pool_ok) begin
                                r_status <= lcqfp_pkg::STAT_EXHAUST;
                            end
                        end
                        lcqfp_pkg::FUNC_INSERT: begin
                            if (!pool_ok) begin
                                r_status <= lcqfp_pkg::STAT_EXHAUST;
                            end else if (i_cmd.before_slot > lcqfp_pkg::NONE_SLOT ||
                                         (i_cmd.before_slot != lcqfp_pkg::NONE_SLOT &&
                                          !r_queued[i_cmd.before_slot[SW-1:0]])) begin
                                r_status <= lcqfp_pkg::STAT_NOTQUEUE;
                            end
                        end
                        lcqfp_pkg::FUNC_POP: begin
                            if (!head_ok) begin
                                r_status <= lcqfp_pkg::STAT_EMPTY;
                            end
                        end
                        default: begin
                            r_status <= lcqfp_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            ST_TAKE: begin
                r_p    <= pv_data;
                r_slot <= r_s;
            end
            ST_REL: begin
                if (!r_op_clr) begin
                    r_slot <= r_head[SW-1:0];
                    r_code <= r_rd_code;
                    r_tag  <= r_rd_tag;
                end
            end
            default: begin
                r_p <= r_p;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (fin_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_o_status <= r_status;
            r_o_slot   <= r_slot;
            r_o_code   <= r_code;
            r_o_tag    <= r_tag;
            r_o_free   <= r_fleft;
            r_o_empty  <= !head_ok;
        end
    end

    assign i_cmd.ready       = r_state == ST_IDLE;
    assign o_res.valid       = r_ov;
    assign o_res.status      = r_o_status;
    assign o_res.slot        = r_o_slot;
    assign o_res.out_code    = r_o_code;
    assign o_res.out_state   = r_o_tag;
    assign o_res.free_count  = r_o_free;
    assign o_res.queue_empty = r_o_empty;

endmodule

### rtl/lcqfp_link_ram.sv
`timescale 1ns / 1ps

// One write, one registered read. Entries never written read as the
// default supplied with the read request.
module lcqfp_link_ram (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lcqfp_pkg::t_link_wr               i_wr,
    input  lcqfp_pkg::t_link_rd               i_rd,
    output logic [lcqfp_pkg::LINK_W-1:0]      o_rd_data
);

    logic [lcqfp_pkg::LINK_W-1:0]     r_mem [lcqfp_pkg::POOL_DEPTH];
    logic [lcqfp_pkg::POOL_DEPTH-1:0] r_written;
    logic [lcqfp_pkg::LINK_W-1:0]     r_q;
    logic [lcqfp_pkg::LINK_W-1:0]     r_dflt;
    logic                             r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr.en) begin
            r_written[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_q    <= r_mem[i_rd.addr];
            r_hit  <= r_written[i_rd.addr];
            r_dflt <= i_rd.dflt;
        end
    end

    assign o_rd_data = r_hit ? r_q : r_dflt;

endmodule

### rtl/lcqfp_chk.sv
`timescale 1ns / 1ps

module lcqfp_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [lcqfp_pkg::STAT_W-1:0]       i_status,
    input logic [lcqfp_pkg::SLOT_W-1:0]       i_slot,
    input logic [lcqfp_pkg::CNT_W-1:0]        i_free_count,
    input logic                               i_queue_empty
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) &&
        $stable(i_slot) && $stable(i_free_count))
        else $error("result beat changed while stalled");

    // one command at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while previous one in flight");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_free_count == lcqfp_pkg::CNT_W'(lcqfp_pkg::POOL_DEPTH)
        |-> i_queue_empty)
        else $error("all slots free but queue not empty");

    a_exhaust: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == lcqfp_pkg::STAT_EXHAUST |-> i_free_count == '0)
        else $error("pool exhausted reported with free slots left");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == lcqfp_pkg::STAT_EMPTY |-> i_queue_empty)
        else $error("queue empty reported on a non-empty queue");

endmodule

bind linked_command_queue_with_free_pool_core lcqfp_chk u_lcqfp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_cmd.valid),
    .i_in_ready    (i_cmd.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_status      (o_res.status),
    .i_slot        (o_res.slot),
    .i_free_count  (o_res.free_count),
    .i_queue_empty (o_res.queue_empty)
);

### test/tb_linked_command_queue_with_free_pool_core.sv
`timescale 1ns / 1ps

module tb_linked_command_queue_with_free_pool_core;
    import lcqfp_pkg::*;

    localparam int RAND_ITEMS  = 1150;
    localparam int WATCH_LIMIT = 4000;   // cycles with no beat on either channel
    localparam int TAIL_CYCLES = 40;     // longest op is a full clear
    localparam int SEND_IDLE [3] = '{35, 72, 0};
    localparam int RECV_IDLE [3] = '{72, 35, 0};

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [CODE_W-1:0]   code;
        logic [TAG_W-1:0]    tag;
        logic [BEFORE_W-1:0] target;
        int                  phase;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [CODE_W-1:0] code;
        logic [TAG_W-1:0]  tag;
        logic [CNT_W-1:0]  free_count;
        logic              qempty;
    } t_res;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Stimulus side registers, fed onto the channels by continuous assigns
    logic                cmd_valid  = 1'b0;
    logic [FUNC_W-1:0]   cmd_func   = '0;
    logic [CODE_W-1:0]   cmd_code   = '0;
    logic [TAG_W-1:0]    cmd_tag    = '0;
    logic [BEFORE_W-1:0] cmd_before = '0;
    logic                res_ready  = 1'b0;

    lcqfp_cmd_if cmd_ch ();
    lcqfp_res_if res_ch ();

    assign cmd_ch.valid       = cmd_valid;
    assign cmd_ch.func        = cmd_func;
    assign cmd_ch.cmd_code    = cmd_code;
    assign cmd_ch.cmd_state   = cmd_tag;
    assign cmd_ch.before_slot = cmd_before;
    assign res_ch.ready       = res_ready;

    linked_command_queue_with_free_pool_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // ------------------------------------------------------------------
    // Pool model. Two copies: [0] runs ahead while the stimulus is built
    // (so inserts can aim at slots that will really be queued), [1] follows
    // the accepted beats and produces the expected results.
    // ------------------------------------------------------------------
    logic [LINK_W-1:0] pool_next   [2][POOL_DEPTH];
    logic [LINK_W-1:0] pool_prev   [2][POOL_DEPTH];
    logic [CODE_W-1:0] pool_code   [2][POOL_DEPTH];
    logic [TAG_W-1:0]  pool_tag    [2][POOL_DEPTH];
    logic              pool_queued [2][POOL_DEPTH];
    logic [LINK_W-1:0] q_head [2];
    logic [LINK_W-1:0] q_tail [2];
    logic [LINK_W-1:0] free_top [2];
    logic [CNT_W-1:0]  free_cnt [2];

    function automatic void pool_reset(int w);
        for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_next[w][i]   = LINK_W'(i + 1);
            pool_prev[w][i]   = NONE_SLOT;
            pool_code[w][i]   = '0;
            pool_tag[w][i]    = '0;
            pool_queued[w][i] = 1'b0;
        end
        q_head[w]   = NONE_SLOT;
        q_tail[w]   = NONE_SLOT;
        free_top[w] = '0;
        free_cnt[w] = CNT_W'(POOL_DEPTH);
    endfunction

    // Pull the front of the free list and fill it
    function automatic logic [SLOT_W-1:0] take_slot(int w, t_cmd c);
        logic [SLOT_W-1:0] s;
        s = free_top[w][SLOT_W-1:0];
        free_top[w]       = pool_next[w][s];
        pool_next[w][s]   = NONE_SLOT;
        pool_prev[w][s]   = NONE_SLOT;
        pool_code[w][s]   = c.code;
        pool_tag[w][s]    = c.tag;
        pool_queued[w][s] = 1'b1;
        free_cnt[w]       = free_cnt[w] - 1'b1;
        return s;
    endfunction

    // Unlink the head and push it onto the front of the free list
    function automatic logic [SLOT_W-1:0] release_head(int w);
        logic [SLOT_W-1:0] s;
        s = q_head[w][SLOT_W-1:0];
        q_head[w] = pool_next[w][s];
        if (q_head[w] < NONE_SLOT) begin
            pool_prev[w][q_head[w][SLOT_W-1:0]] = NONE_SLOT;
        end else begin
            q_tail[w] = NONE_SLOT;
        end
        pool_queued[w][s] = 1'b0;
        pool_prev[w][s]   = NONE_SLOT;
        pool_next[w][s]   = free_top[w];
        free_top[w]       = {1'b0, s};
        free_cnt[w]       = free_cnt[w] + 1'b1;
        return s;
    endfunction

    function automatic t_res apply_cmd(int w, t_cmd c);
        t_res              r;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] b;
        logic [LINK_W-1:0] bp;
        r = '0;
        case (c.func)
            FUNC_APPEND, FUNC_INSERT: begin
                // exhaustion wins over a bad slot
                if (free_top[w] >= NONE_SLOT || free_cnt[w] == '0) begin
                    r.status = STAT_EXHAUST;
                end else if (c.func == FUNC_APPEND || c.target == NONE_SLOT) begin
                    s = take_slot(w, c);
                    pool_prev[w][s] = q_tail[w];
                    if (q_tail[w] < NONE_SLOT) begin
                        pool_next[w][q_tail[w][SLOT_W-1:0]] = {1'b0, s};
                    end else begin
                        q_head[w] = {1'b0, s};
                    end
                    q_tail[w] = {1'b0, s};
                    r.slot    = s;
                end else if (c.target > NONE_SLOT
                             || !pool_queued[w][c.target[SLOT_W-1:0]]) begin
                    r.status = STAT_NOTQUEUE;
                end else begin
                    b  = c.target[SLOT_W-1:0];
                    s  = take_slot(w, c);
                    bp = pool_prev[w][b];
                    pool_prev[w][s] = bp;
                    pool_next[w][s] = {1'b0, b};
                    if (bp < NONE_SLOT) begin
                        pool_next[w][bp[SLOT_W-1:0]] = {1'b0, s};
                    end else begin
                        q_head[w] = {1'b0, s};
                    end
                    pool_prev[w][b] = {1'b0, s};
                    r.slot = s;
                end
            end
            FUNC_POP: begin
                if (q_head[w] >= NONE_SLOT) begin
                    r.status = STAT_EMPTY;
                end else begin
                    s      = release_head(w);
                    r.slot = s;
                    r.code = pool_code[w][s];
                    r.tag  = pool_tag[w][s];
                end
            end
            default: begin
                while (q_head[w] < NONE_SLOT) begin
                    s = release_head(w);
                end
            end
        endcase
        r.free_count = free_cnt[w];
        r.qempty     = (q_head[w] >= NONE_SLOT);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus build
    // ------------------------------------------------------------------
    t_cmd pending_cmds [$];
    t_res expected_res [$];

    function automatic void add_cmd(logic [FUNC_W-1:0] f, logic [CODE_W-1:0] code,
                                    logic [TAG_W-1:0] tag, logic [BEFORE_W-1:0] target,
                                    int ph);
        t_cmd c;
        c.func   = f;
        c.code   = code;
        c.tag    = tag;
        c.target = target;
        c.phase  = ph;
        void'(apply_cmd(0, c));
        pending_cmds.push_back(c);
    endfunction

    // Random slot from those queued in the look-ahead copy, or none if empty
    function automatic logic [BEFORE_W-1:0] pick_queued();
        int n;
        int k;
        n = 0;
        for (int i = 0; i < POOL_DEPTH; i++) n += pool_queued[0][i];
        if (n == 0) return NONE_SLOT;
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < POOL_DEPTH; i++) begin
            if (pool_queued[0][i]) begin
                if (k == 0) return BEFORE_W'(i);
                k--;
            end
        end
        return NONE_SLOT;
    endfunction

    function automatic void add_random(int ph, bit filling);
        int                  roll;
        int                  pick;
        logic [FUNC_W-1:0]   f;
        logic [BEFORE_W-1:0] target;
        roll   = $urandom_range(0, 99);
        target = BEFORE_W'($urandom_range(0, 31));
        if (roll < (filling ? 35 : 15))      f = FUNC_APPEND;
        else if (roll < (filling ? 76 : 35)) f = FUNC_INSERT;
        else if (roll < (filling ? 98 : 96)) f = FUNC_POP;
        else                                  f = FUNC_CLEAR;
        if (f == FUNC_INSERT) begin
            // mostly aim at live entries, with some no-slot and bad targets
            pick = $urandom_range(0, 99);
            if (pick < 70)      target = pick_queued();
            else if (pick < 85) target = NONE_SLOT;
            else if (pick < 95) target = BEFORE_W'($urandom_range(0, POOL_DEPTH - 1));
            else                target = BEFORE_W'($urandom_range(POOL_DEPTH + 1, 31));
        end
        add_cmd(f, CODE_W'($urandom), TAG_W'($urandom), target, ph);
    endfunction

    // ------------------------------------------------------------------
    // Driver, receiver and checker
    // ------------------------------------------------------------------
    t_cmd cmd_live;
    int   cmd_sent    = 0;
    int   cmd_done    = 0;
    int   cur_phase   = 0;
    int   idle_cycles = 0;
    int   err_cnt     = 0;
    int   res_cnt     = 0;
    int   op_seen   [4] = '{0, 0, 0, 0};
    int   stat_seen [4] = '{0, 0, 0, 0};

    // New beat only once the previous one has gone; valid is never dropped mid-beat
    always @(negedge i_clk) begin
        if (i_rst_n && cmd_done == cmd_sent) begin
            if (pending_cmds.size() != 0
                && $urandom_range(0, 99) >= SEND_IDLE[pending_cmds[0].phase]) begin
                cmd_live   = pending_cmds.pop_front();
                cur_phase  <= cmd_live.phase;
                cmd_func   <= cmd_live.func;
                cmd_code   <= cmd_live.code;
                cmd_tag    <= cmd_live.tag;
                cmd_before <= cmd_live.target;
                cmd_valid  <= 1'b1;
                cmd_sent   <= cmd_sent + 1;
            end else begin
                cmd_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            res_ready <= ($urandom_range(0, 99) >= RECV_IDLE[cur_phase]);
        end
    end

    always @(posedge i_clk) begin
        t_res exp_r;
        t_res got;
        bit   progress;
        progress = 1'b0;
        if (i_rst_n) begin
            // result first: it always belongs to an earlier command
            if (res_ch.valid && res_ch.ready) begin
                progress = 1'b1;
                res_cnt++;
                got = '{res_ch.status, res_ch.slot, res_ch.out_code, res_ch.out_state,
                        res_ch.free_count, res_ch.queue_empty};
                if (expected_res.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("[%0t] result with nothing outstanding: status=%0d slot=%0d",
                                 $realtime, got.status, got.slot);
                end else begin
                    exp_r = expected_res.pop_front();
                    stat_seen[exp_r.status]++;
                    if (got.status !== exp_r.status || got.slot !== exp_r.slot
                        || got.code !== exp_r.code || got.tag !== exp_r.tag
                        || got.free_count !== exp_r.free_count
                        || got.qempty !== exp_r.qempty) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("[%0t] mismatch on result %0d", $realtime, res_cnt);
                            $display("  exp st=%0d slot=%0d code=%02h tag=%02h free=%0d emp=%0d",
                                     exp_r.status, exp_r.slot, exp_r.code, exp_r.tag,
                                     exp_r.free_count, exp_r.qempty);
                            $display("  got st=%0d slot=%0d code=%02h tag=%02h free=%0d emp=%0d",
                                     got.status, got.slot, got.code, got.tag,
                                     got.free_count, got.qempty);
                        end
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                progress = 1'b1;
                expected_res.push_back(apply_cmd(1, cmd_live));
                op_seen[cmd_live.func]++;
                cmd_done <= cmd_done + 1;
            end
        end
        idle_cycles <= progress ? 0 : idle_cycles + 1;
    end

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a long spell with no beat on either side means a hang
    initial begin
        while (idle_cycles < WATCH_LIMIT) @(posedge i_clk);
        $display("Timeout: no beat for %0d cycles", WATCH_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        bit filling;
        int run_len;
        pool_reset(0);
        pool_reset(1);

        // Directed: empty-queue errors, insert without a slot, insert at the
        // head and in the middle, bad targets, field extremes, full pool
        add_cmd(FUNC_POP,    8'h00, 8'h00, 5'd0,      0);
        add_cmd(FUNC_CLEAR,  8'hff, 8'hff, 5'd31,     0);
        add_cmd(FUNC_INSERT, 8'h00, 8'hff, NONE_SLOT, 0);  // slot 0
        add_cmd(FUNC_INSERT, 8'hff, 8'h00, 5'd0,      0);  // new head
        add_cmd(FUNC_APPEND, 8'ha5, 8'h5a, 5'd0,      0);
        add_cmd(FUNC_INSERT, 8'h3c, 8'hc3, 5'd0,      0);  // middle
        add_cmd(FUNC_INSERT, 8'h11, 8'h22, 5'd15,     0);  // not queued
        add_cmd(FUNC_INSERT, 8'h33, 8'h44, 5'd31,     0);  // out of range
        add_cmd(FUNC_POP,    8'h00, 8'h00, 5'd0,      0);
        add_cmd(FUNC_INSERT, 8'h55, 8'h66, q_tail[0], 0);  // ahead of the tail
        while (free_cnt[0] != '0)
            add_cmd(FUNC_APPEND, CODE_W'($urandom), TAG_W'($urandom), 5'd0, 0);
        add_cmd(FUNC_APPEND, 8'h77, 8'h88, 5'd0,  0);       // pool exhausted
        add_cmd(FUNC_INSERT, 8'h99, 8'haa, 5'd31, 0);       // exhaustion beats bad slot
        add_cmd(FUNC_INSERT, 8'hbb, 8'hcc, q_head[0], 0);
        add_cmd(FUNC_CLEAR,  8'h00, 8'h00, 5'd0,  0);       // clear of a full queue
        add_cmd(FUNC_POP,    8'h00, 8'h00, 5'd0,  0);

        // Random: alternating fill and drain spells so that both the full pool
        // and the empty queue come round often
        filling = 1'b1;
        run_len = 0;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (run_len == 0) begin
                filling = ~filling;
                run_len = $urandom_range(15, 50);
            end
            run_len--;
            add_random(i * 3 / RAND_ITEMS, filling);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_cmds.size() != 0 || cmd_done != cmd_sent || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_res.size() != 0) err_cnt++;

        $display("Ran %0d commands: %0d append, %0d insert, %0d pop, %0d clear",
                 cmd_done, op_seen[FUNC_APPEND], op_seen[FUNC_INSERT],
                 op_seen[FUNC_POP], op_seen[FUNC_CLEAR]);
        $display("Results: %0d ok, %0d pool full, %0d queue empty, %0d bad slot; %0d errors",
                 stat_seen[STAT_OK], stat_seen[STAT_EXHAUST], stat_seen[STAT_EMPTY],
                 stat_seen[STAT_NOTQUEUE], err_cnt);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
rtl/lcqfp_pkg.sv
rtl/lcqfp_if.sv
rtl/lcqfp_link_ram.sv
rtl/linked_command_queue_with_free_pool_core.sv
rtl/lcqfp_chk.sv
test/tb_linked_command_queue_with_free_pool_core.sv
